/* hw/rtl/dse_pkg.sv */
// Shared constants, codes and types for the data stack engine.
package dse_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WORD_W      = 64;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_DUP    = 3'd1,
    REQ_DROP   = 3'd2,
    REQ_SWAP   = 3'd3,
    REQ_ROT    = 3'd4,
    REQ_PICK   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  // Which cached entry takes the memory read data.
  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_T2,
    FILL_T0
  } fill_t;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] top;
    logic [CNT_W-1:0]  count;
    stat_t             status;
  } result_t;

endpackage

/* hw/rtl/dse_stack_ram.sv */
// Stack entry memory: one write port, one read port, registered read data.
module dse_stack_ram (
  input  logic                                clk,
  input  dse_pkg::mem_req_t                   req,
  output logic [dse_pkg::WORD_W-1:0]          rdata
);

  logic [dse_pkg::WORD_W-1:0] mem [dse_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

/* hw/rtl/dse_ctrl.sv */
// Request sequencer: depth counter, top-three cache, spill and refill control.
module dse_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2:0]                    req_type,
  input  logic [dse_pkg::WORD_W-1:0]    push_value,
  input  logic [dse_pkg::WORD_W-1:0]    rdata,
  output logic                          busy,
  output dse_pkg::mem_req_t             mem_req,
  output dse_pkg::result_t              result
);

  localparam int unsigned AW = dse_pkg::ADDR_W;
  localparam int unsigned CW = dse_pkg::CNT_W;
  localparam int unsigned WW = dse_pkg::WORD_W;

  dse_pkg::state_t state, state_next;
  dse_pkg::fill_t  fill, fill_next;
  dse_pkg::stat_t  status, status_next;
  logic [CW-1:0]   count, count_next;
  // t0 is the top; memory holds only entries below the cached three
  logic [WW-1:0]   t0, t1, t2;
  logic [WW-1:0]   t0_next, t1_next, t2_next;

  logic            full;
  logic [CW-1:0]   cnt_m1;
  logic            pick_bad;
  logic [AW-1:0]   pick_n;

  assign full     = (count == CW'(dse_pkg::STACK_DEPTH));
  assign cnt_m1   = count - CW'(1);
  assign pick_bad = t0[WW-1] || (t0 >= WW'(cnt_m1));
  assign pick_n   = t0[AW-1:0];

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    status_next   = status;
    count_next    = count;
    t0_next       = t0;
    t1_next       = t1;
    t2_next       = t2;
    mem_req.we    = 1'b0;
    mem_req.waddr = AW'(count - CW'(3));
    mem_req.wdata = t2;
    mem_req.raddr = AW'(count - CW'(4));
    result.load   = 1'b0;

    case (state)
      dse_pkg::ST_IDLE: begin
        if (start) begin
          state_next  = dse_pkg::ST_FILL;
          fill_next   = dse_pkg::FILL_NONE;
          status_next = dse_pkg::STAT_OK;
          case (dse_pkg::req_t'(req_type))
            dse_pkg::REQ_PUSH, dse_pkg::REQ_DUP: begin
              if (req_type == dse_pkg::REQ_DUP && count == '0) begin
                status_next = dse_pkg::STAT_UNDER;
              end else if (full) begin
                status_next = dse_pkg::STAT_OVER;
              end else begin
                t0_next    = (req_type == dse_pkg::REQ_DUP) ? t0 : push_value;
                t1_next    = t0;
                t2_next    = t1;
                count_next = count + CW'(1);
                // spill the third entry once it leaves the cache
                mem_req.we = (count >= CW'(3));
              end
            end
            dse_pkg::REQ_DROP: begin
              if (count == '0) begin
                status_next = dse_pkg::STAT_UNDER;
              end else begin
                t0_next    = t1;
                t1_next    = t2;
                count_next = cnt_m1;
                if (count >= CW'(4)) begin
                  fill_next = dse_pkg::FILL_T2;
                end
              end
            end
            dse_pkg::REQ_SWAP: begin
              if (count < CW'(2)) begin
                status_next = dse_pkg::STAT_UNDER;
              end else begin
                t0_next = t1;
                t1_next = t0;
              end
            end
            dse_pkg::REQ_ROT: begin
              if (count < CW'(3)) begin
                status_next = dse_pkg::STAT_UNDER;
              end else begin
                t0_next = t2;
                t1_next = t0;
                t2_next = t1;
              end
            end
            dse_pkg::REQ_PICK: begin
              if (count == '0) begin
                status_next = dse_pkg::STAT_UNDER;
              end else if (pick_bad) begin
                status_next = dse_pkg::STAT_RANGE;
              end else if (pick_n == AW'(0)) begin
                t0_next = t1;
              end else if (pick_n == AW'(1)) begin
                t0_next = t2;
              end else begin
                // entry deeper than the cache reaches: fetch it
                fill_next     = dse_pkg::FILL_T0;
                mem_req.raddr = AW'(count - CW'(2) - CW'(pick_n));
              end
            end
            default: begin
            end
          endcase
        end
      end
      dse_pkg::ST_FILL: begin
        case (fill)
          dse_pkg::FILL_T2: t2_next = rdata;
          dse_pkg::FILL_T0: t0_next = rdata;
          default: begin
          end
        endcase
        fill_next   = dse_pkg::FILL_NONE;
        result.load = 1'b1;
        state_next  = dse_pkg::ST_IDLE;
      end
      default: begin
        state_next = dse_pkg::ST_IDLE;
      end
    endcase

    result.top    = (count != '0) ? t0_next : '0;
    result.count  = count;
    result.status = status;
  end

  assign busy = (state != dse_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dse_pkg::ST_IDLE;
      fill   <= dse_pkg::FILL_NONE;
      count  <= '0;
      status <= dse_pkg::STAT_OK;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      count  <= count_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    t0 <= t0_next;
    t1 <= t1_next;
    t2 <= t2_next;
  end

endmodule

/* hw/rtl/data_stack_engine_unit.sv */
// Result beat: an accepted request moves the sequencer to its fill state, which
// loads the output register; no new request is taken before the fill state ends,
// where the memory read data refills the cached top entries (drop, deep pick).
// Reset (rst, synchronous, active high) empties the stack at once; entry memory
// is not cleared, since no entry is read before it is written.
// Top-level: data stack with top three entries cached in registers.
module data_stack_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic signed [63:0]            push_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [63:0]            top_value,
  output logic [8:0]                    stack_count,
  output logic [1:0]                    status
);

  logic                        busy;
  logic                        start;
  dse_pkg::mem_req_t           mem_req;
  logic [dse_pkg::WORD_W-1:0]  rdata;
  dse_pkg::result_t            result;

  // A new request may enter while the last result beat leaves the output
  // register; its result is not loaded until the following cycle.
  assign in_stall = busy || (out_valid && out_stall);
  assign start    = in_valid && !in_stall;

  dse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .push_value (push_value),
    .rdata      (rdata),
    .busy       (busy),
    .mem_req    (mem_req),
    .result     (result)
  );

  dse_stack_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Output register: holds the beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      top_value   <= result.top;
      stack_count <= result.count;
      status      <= result.status;
    end
  end

endmodule

/* hw/rtl/dse_checker.sv */
// Port-level checker for the data stack engine, bound to the top level.
module dse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] top_value,
  input logic [8:0]  stack_count,
  input logic [1:0]  status
);

  // one request in flight: no accept on the edge after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in flight");

  // every accepted request yields a result beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("result beat missing after request");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stack_count <= 9'd256))
    else $error("stack depth beyond capacity");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stack_count == 9'd0) |-> (top_value == 64'd0))
    else $error("nonzero top on empty stack");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind data_stack_engine_unit dse_checker u_dse_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .top_value   (top_value),
  .stack_count (stack_count),
  .status      (status)
);
